[rtl/qdd_pkg.sv]
// Quadrature detent decoder package: register map, item layout, step codes.
// Shared by the decoder core and the top level; no dependencies.
`default_nettype none

package qdd_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned LockoutW  = 8;
  localparam int unsigned CountW    = 4;
  localparam int unsigned DirW      = 2;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 8;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [LockoutW-1:0] LockoutReset = 8'd5;
  localparam logic [CountW-1:0]   StepsReset   = 4'd3;

  localparam logic [DirW-1:0] DirNone = 2'b00;
  localparam logic [DirW-1:0] DirCw   = 2'b01;
  localparam logic [DirW-1:0] DirCcw  = 2'b11;

  typedef enum logic [0:0] {
    REG_LOCKOUT = 1'b0,
    REG_STEPS   = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    STEP_HOLD = 2'd0,
    STEP_CW   = 2'd1,
    STEP_JUMP = 2'd2,
    STEP_CCW  = 2'd3
  } step_e;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             pin_b;
    logic             pin_a;
  } item_t;

  typedef struct packed {
    logic [CountW-1:0]   steps_per_detent;
    logic [LockoutW-1:0] lockout_ms;
  } cfg_t;

  function automatic logic [1:0] gray_of(input logic a, input logic b);
    logic [1:0] raw;
    raw = {a, b};
    gray_of = {raw[1], raw[1] ^ raw[0]};
  endfunction

endpackage

`default_nettype wire

[rtl/qdd_core.sv]
// Decoder core: position, step time, step counters; one item per advance_i cycle.
// Depends on qdd_pkg for item, config and step types.
`default_nettype none

module qdd_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      advance_i,
  input  wire qdd_pkg::item_t            item_i,
  input  wire qdd_pkg::cfg_t             cfg_i,
  output logic [qdd_pkg::DirW-1:0]       dir_o
);

  logic                          primed_q, primed_d;
  logic [1:0]                    last_pos_q, last_pos_d;
  logic [qdd_pkg::TimeW-1:0]     last_time_q, last_time_d;
  logic [qdd_pkg::CountW-1:0]    cw_q, cw_d;
  logic [qdd_pkg::CountW-1:0]    ccw_q, ccw_d;

  logic [1:0]                    pos;
  logic [qdd_pkg::TimeW-1:0]     elapsed;
  logic                          locked;
  logic [qdd_pkg::CountW-1:0]    cw_inc, ccw_inc;
  qdd_pkg::step_e                step;

  assign pos     = qdd_pkg::gray_of(item_i.pin_a, item_i.pin_b);
  assign elapsed = item_i.now_ms - last_time_q;
  assign locked  = elapsed <= {{(qdd_pkg::TimeW-qdd_pkg::LockoutW){1'b0}}, cfg_i.lockout_ms};
  assign cw_inc  = cw_q + 1'b1;
  assign ccw_inc = ccw_q + 1'b1;
  assign step    = qdd_pkg::step_e'(last_pos_q - pos);

  always_comb begin
    primed_d    = primed_q;
    last_pos_d  = last_pos_q;
    last_time_d = last_time_q;
    cw_d        = cw_q;
    ccw_d       = ccw_q;
    dir_o       = qdd_pkg::DirNone;
    if (!primed_q) begin
      primed_d    = 1'b1;
      last_pos_d  = pos;
      last_time_d = item_i.now_ms;
    end else if (!locked) begin
      last_pos_d = pos;
      unique case (step)
        qdd_pkg::STEP_CW: begin
          ccw_d       = '0;
          last_time_d = item_i.now_ms;
          if (cw_inc == cfg_i.steps_per_detent) begin
            cw_d  = '0;
            dir_o = qdd_pkg::DirCw;
          end else begin
            cw_d = cw_inc;
          end
        end
        qdd_pkg::STEP_CCW: begin
          cw_d        = '0;
          last_time_d = item_i.now_ms;
          if (ccw_inc == cfg_i.steps_per_detent) begin
            ccw_d = '0;
            dir_o = qdd_pkg::DirCcw;
          end else begin
            ccw_d = ccw_inc;
          end
        end
        qdd_pkg::STEP_JUMP: begin
          last_time_d = item_i.now_ms;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      last_pos_q  <= '0;
      last_time_q <= '0;
      cw_q        <= '0;
      ccw_q       <= '0;
    end else if (advance_i) begin
      primed_q    <= primed_d;
      last_pos_q  <= last_pos_d;
      last_time_q <= last_time_d;
      cw_q        <= cw_d;
      ccw_q       <= ccw_d;
    end
  end

endmodule

`default_nettype wire

[rtl/quadrature_detent_decoder.sv]
// Pipeline: input register, then result register, from input accept to result valid.
// Throughput: one item per cycle unless the output stalls; decoder core state updates
// as an item leaves the input register, so consecutive items chain at full rate.
// Reset (rst_ni low, asynchronous): pipeline empty, decoder unprimed, counts and
// step time cleared, lockout_ms = 5, steps_per_detent = 3.
`default_nettype none

module quadrature_detent_decoder (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [0] pin_a, [1] pin_b, [33:2] now_ms, [39:34] zero
  input  wire logic [qdd_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [1:0] detent_dir, [7:2] zero
  output logic [qdd_pkg::OutDataW-1:0]          m_axis_tdata,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [qdd_pkg::ApbAddrW-1:0]     paddr,
  input  wire logic [qdd_pkg::ApbDataW-1:0]     pwdata,
  output logic [qdd_pkg::ApbDataW-1:0]          prdata,
  output logic                                  pready
);

  qdd_pkg::cfg_t                   cfg_q;
  qdd_pkg::item_t                  item_q;
  logic                            in_valid_q;
  logic                            out_valid_q;
  logic [qdd_pkg::DirW-1:0]        out_dir_q;
  logic [qdd_pkg::DirW-1:0]        dir;
  logic                            advance;
  logic                            cfg_wr;
  qdd_pkg::reg_idx_e               reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = qdd_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      qdd_pkg::REG_LOCKOUT: prdata[qdd_pkg::LockoutW-1:0] = cfg_q.lockout_ms;
      qdd_pkg::REG_STEPS:   prdata[qdd_pkg::CountW-1:0]   = cfg_q.steps_per_detent;
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lockout_ms       <= qdd_pkg::LockoutReset;
      cfg_q.steps_per_detent <= qdd_pkg::StepsReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        qdd_pkg::REG_LOCKOUT: cfg_q.lockout_ms <= pwdata[qdd_pkg::LockoutW-1:0];
        qdd_pkg::REG_STEPS:   cfg_q.steps_per_detent <= pwdata[qdd_pkg::CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= s_axis_tdata[$bits(qdd_pkg::item_t)-1:0];
    end
    if (advance) begin
      out_dir_q <= dir;
    end
  end

  qdd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg_q),
    .dir_o     (dir)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(qdd_pkg::OutDataW-qdd_pkg::DirW){1'b0}}, out_dir_q};

endmodule

`default_nettype wire

[rtl/qdd_checker.sv]
// Port-level checks for the quadrature detent decoder, bound to the top level.
// Depends on qdd_pkg for widths and direction codes.
`default_nettype none

module qdd_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [qdd_pkg::OutDataW-1:0]     m_axis_tdata
);

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result dropped under stall");

  property p_dir_code;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |-> (m_axis_tdata[qdd_pkg::DirW-1:0] == qdd_pkg::DirNone ||
                         m_axis_tdata[qdd_pkg::DirW-1:0] == qdd_pkg::DirCw ||
                         m_axis_tdata[qdd_pkg::DirW-1:0] == qdd_pkg::DirCcw);
  endproperty
  a_dir_code: assert property (p_dir_code) else $error("invalid detent direction");

  property p_pad_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |-> m_axis_tdata[qdd_pkg::OutDataW-1:qdd_pkg::DirW] == '0;
  endproperty
  a_pad_zero: assert property (p_pad_zero) else $error("nonzero result padding");

  property p_stall_cause;
    @(posedge clk_i) disable iff (!rst_ni)
      !s_axis_tready |-> m_axis_tvalid && !m_axis_tready;
  endproperty
  a_stall_cause: assert property (p_stall_cause) else $error("input stalled without backpressure");

  property p_fill;
    @(posedge clk_i) disable iff (!rst_ni)
      s_axis_tvalid && s_axis_tready && !m_axis_tvalid ##1 !m_axis_tvalid |=> m_axis_tvalid;
  endproperty
  a_fill: assert property (p_fill) else $error("accepted item did not reach output");

endmodule

bind quadrature_detent_decoder qdd_checker u_qdd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[verif/quadrature_detent_decoder_tb.sv]
// Self-checking testbench for the quadrature detent decoder: random bursts of pin samples
// are checked against an in-bench detent predictor over several register settings.
// Depends on rtl/qdd_pkg.sv and rtl/quadrature_detent_decoder.sv.
module quadrature_detent_decoder_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 216;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [qdd_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [qdd_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [qdd_pkg::ApbAddrW-1:0] paddr = '0;
  logic [qdd_pkg::ApbDataW-1:0] pwdata = '0;
  logic [qdd_pkg::ApbDataW-1:0] prdata;
  logic                         pready;

  quadrature_detent_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  qdd_pkg::item_t               sample_q[$];
  logic [qdd_pkg::DirW-1:0]     detent_q[$];
  qdd_pkg::item_t               offered;
  logic [qdd_pkg::DirW-1:0]     want_dir;

  logic [qdd_pkg::LockoutW-1:0] cfg_lockout = qdd_pkg::LockoutReset;
  logic [qdd_pkg::CountW-1:0]   cfg_steps = qdd_pkg::StepsReset;
  logic                         st_primed = 1'b0;
  logic [1:0]                   st_pos = '0;
  logic [qdd_pkg::TimeW-1:0]    st_step_ms = '0;
  logic [qdd_pkg::CountW-1:0]   st_cw = '0;
  logic [qdd_pkg::CountW-1:0]   st_ccw = '0;

  logic [1:0]                   gen_pos = '0;
  logic [qdd_pkg::TimeW-1:0]    gen_ms = '0;
  logic                         gen_cw = 1'b1;

  int unsigned fail_count = 0;
  int unsigned samples_taken = 0;
  int unsigned locked_out = 0;
  int unsigned cw_detents = 0;
  int unsigned ccw_detents = 0;
  int unsigned settings_used = 1;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  int unsigned ready_mode = 0;
  logic        long_hold_done = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void predict_detent(input qdd_pkg::item_t s);
    logic [1:0]                pos;
    logic [qdd_pkg::TimeW-1:0] elapsed;
    logic [qdd_pkg::DirW-1:0]  dir;
    qdd_pkg::step_e            mv;
    pos = {s.pin_a, s.pin_a ^ s.pin_b};
    dir = qdd_pkg::DirNone;
    samples_taken++;
    elapsed = s.now_ms - st_step_ms;
    if (!st_primed) begin
      st_primed = 1'b1;
      st_pos = pos;
      st_step_ms = s.now_ms;
    end else if (elapsed <= qdd_pkg::TimeW'(cfg_lockout)) begin
      locked_out++;
    end else begin
      mv = qdd_pkg::step_e'(st_pos - pos);
      case (mv)
        qdd_pkg::STEP_CW: begin
          st_ccw = '0;
          st_cw = st_cw + 1'b1;
          if (st_cw == cfg_steps) begin
            st_cw = '0;
            dir = qdd_pkg::DirCw;
            cw_detents++;
          end
          st_step_ms = s.now_ms;
        end
        qdd_pkg::STEP_CCW: begin
          st_cw = '0;
          st_ccw = st_ccw + 1'b1;
          if (st_ccw == cfg_steps) begin
            st_ccw = '0;
            dir = qdd_pkg::DirCcw;
            ccw_detents++;
          end
          st_step_ms = s.now_ms;
        end
        qdd_pkg::STEP_JUMP: st_step_ms = s.now_ms;
        default: ;
      endcase
      st_pos = pos;
    end
    detent_q.push_back(dir);
  endfunction

  function automatic void push_pos(input logic [1:0] p, input logic [qdd_pkg::TimeW-1:0] t);
    qdd_pkg::item_t s;
    s.pin_a = p[1];
    s.pin_b = p[1] ^ p[0];
    s.now_ms = t;
    sample_q.push_back(s);
  endfunction

  // sender: bursts of random length, random gaps between them
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_detent(offered);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          offered = sample_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= qdd_pkg::InDataW'(offered);
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: one long hold-off, otherwise a changing ready pattern
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 400) begin
      long_hold_done = 1'b1;
      hold_left = 299;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (detent_q.size() == 0) begin
        $error("detent_dir: no item expected, actual %b", m_axis_tdata[qdd_pkg::DirW-1:0]);
        fail_count++;
      end else begin
        want_dir = detent_q.pop_front();
        if (m_axis_tdata[qdd_pkg::DirW-1:0] !== want_dir) begin
          $error("detent_dir: expected %b, actual %b", want_dir,
                 m_axis_tdata[qdd_pkg::DirW-1:0]);
          fail_count++;
        end
        if (m_axis_tdata[qdd_pkg::OutDataW-1:qdd_pkg::DirW] !== '0) begin
          $error("tdata pad: expected 0, actual %h",
                 m_axis_tdata[qdd_pkg::OutDataW-1:qdd_pkg::DirW]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic drain_block();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || s_axis_tvalid || detent_q.size() != 0);
  endtask

  task automatic set_register(input qdd_pkg::reg_idx_e idx,
                              input logic [qdd_pkg::ApbDataW-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      qdd_pkg::REG_LOCKOUT: cfg_lockout = value[qdd_pkg::LockoutW-1:0];
      default: cfg_steps = value[qdd_pkg::CountW-1:0];
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== value) begin
      $error("prdata: expected %h, actual %h", value, prdata);
      fail_count++;
    end
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic roam(input int unsigned n);
    int unsigned               kind;
    logic [qdd_pkg::TimeW-1:0] hop;
    repeat (n) begin
      kind = $urandom_range(0, 99);
      hop = qdd_pkg::TimeW'(cfg_lockout) + 1 +
            (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20));
      if (kind < 70) begin
        if ($urandom_range(0, 9) == 0) gen_cw = !gen_cw;
        gen_pos = gen_cw ? gen_pos - 2'd1 : gen_pos + 2'd1;
        gen_ms = gen_ms + hop;
        push_pos(gen_pos, gen_ms);
      end else if (kind < 80) begin
        push_pos(2'($urandom_range(0, 3)), gen_ms + $urandom_range(0, cfg_lockout));
      end else if (kind < 88) begin
        gen_ms = gen_ms + hop;
        push_pos(gen_pos, gen_ms);
      end else if (kind < 93) begin
        gen_pos = gen_pos + 2'd2;
        gen_ms = gen_ms + hop;
        push_pos(gen_pos, gen_ms);
      end else begin
        gen_pos = 2'($urandom_range(0, 3));
        gen_ms = $urandom();
        push_pos(gen_pos, gen_ms);
      end
    end
  endtask

  initial begin
    logic [qdd_pkg::LockoutW-1:0] lock_plan[7];
    logic [qdd_pkg::CountW-1:0]   step_plan[7];
    lock_plan = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0};
    step_plan = '{4'd1, 4'd15, 4'd15, 4'd1, 4'd0, 4'd0, 4'd0};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_pos(2'd2, 32'hFFFF_FFF0);
    push_pos(2'd0, 32'hFFFF_FFF5);
    push_pos(2'd1, 32'hFFFF_FFF6);
    push_pos(2'd0, 32'hFFFF_FFFD);
    push_pos(2'd3, 32'h0000_0002);
    push_pos(2'd3, 32'h0000_0010);
    push_pos(2'd1, 32'h0000_0020);
    push_pos(2'd1, 32'h0000_0022);
    push_pos(2'd2, 32'h0000_0030);
    push_pos(2'd3, 32'h0000_0040);
    push_pos(2'd0, 32'h0000_0050);
    push_pos(2'd3, 32'h0000_0060);
    push_pos(2'd0, 32'h0000_0070);
    push_pos(2'd1, 32'h0000_0000);
    push_pos(2'd2, 32'hFFFF_FFFF);
    push_pos(2'd3, 32'h5555_5555);
    push_pos(2'd0, 32'hAAAA_AAAA);
    push_pos(2'd0, 32'hAAAA_AAB0);
    gen_pos = 2'd0;
    gen_ms = 32'hAAAA_AAB0;
    roam(PhaseItems);

    foreach (lock_plan[i]) begin
      if (i >= 4) begin
        lock_plan[i] = qdd_pkg::LockoutW'($urandom_range(0, 255));
        step_plan[i] = qdd_pkg::CountW'($urandom_range(1, 15));
      end
      drain_block();
      set_register(qdd_pkg::REG_LOCKOUT, qdd_pkg::ApbDataW'(lock_plan[i]));
      set_register(qdd_pkg::REG_STEPS, qdd_pkg::ApbDataW'(step_plan[i]));
      settings_used++;
      roam(PhaseItems);
    end

    drain_block();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d samples over %0d register settings (%0d inside lockout).",
             samples_taken, settings_used, locked_out);
    $display("Detents seen: %0d clockwise, %0d counterclockwise.", cw_detents, ccw_detents);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
